[rtl/fkda_pkg.sv]
// ============================================================================
// fkda_pkg
// Shared types and constants for the five-key debounce and auto-repeat unit.
// ============================================================================
`default_nettype none

package fkda_pkg;

    localparam int NUM_KEYS   = 5;
    localparam int KEY_UP     = 0;
    localparam int KEY_DOWN   = 1;
    localparam int KEY_LEFT   = 2;
    localparam int KEY_RIGHT  = 3;
    localparam int KEY_CENTER = 4;

    localparam int CFG_WIDTH  = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_LOCKOUT         = 2'd0,
        REG_REPEAT_START    = 2'd1,
        REG_REPEAT_INTERVAL = 2'd2
    } fkda_reg_e;

    localparam logic [CFG_WIDTH-1:0] LOCKOUT_RST         = 16'd50;
    localparam logic [CFG_WIDTH-1:0] REPEAT_START_RST    = 16'd500;
    localparam logic [CFG_WIDTH-1:0] REPEAT_INTERVAL_RST = 16'd100;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] lockout_ms;
        logic [CFG_WIDTH-1:0] repeat_start_ms;
        logic [CFG_WIDTH-1:0] repeat_interval_ms;
    } fkda_cfg_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0] evt;
        logic [NUM_KEYS-1:0] held;
    } fkda_result_t;

endpackage

`default_nettype wire

[rtl/fkda_in_if.sv]
// ============================================================================
// fkda_in_if
// Sample channel: timestamp and five key levels with valid/ready.
// ============================================================================
`default_nettype none

interface fkda_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        level_up;
    logic        level_down;
    logic        level_left;
    logic        level_right;
    logic        level_center;

    modport source (
        output valid, now_ms, level_up, level_down, level_left, level_right, level_center,
        input  ready
    );
    modport sink (
        input  valid, now_ms, level_up, level_down, level_left, level_right, level_center,
        output ready
    );
endinterface

`default_nettype wire

[rtl/fkda_out_if.sv]
// ============================================================================
// fkda_out_if
// Result channel: five event flags and five held flags with valid/ready.
// ============================================================================
`default_nettype none

interface fkda_out_if;
    logic valid;
    logic ready;
    logic event_up;
    logic event_down;
    logic event_left;
    logic event_right;
    logic event_center;
    logic held_up;
    logic held_down;
    logic held_left;
    logic held_right;
    logic held_center;

    modport source (
        output valid, event_up, event_down, event_left, event_right, event_center,
               held_up, held_down, held_left, held_right, held_center,
        input  ready
    );
    modport sink (
        input  valid, event_up, event_down, event_left, event_right, event_center,
               held_up, held_down, held_left, held_right, held_center,
        output ready
    );
endinterface

`default_nettype wire

[rtl/five_key_debounce_autorepeat_unit.sv]
// ============================================================================
// five_key_debounce_autorepeat_unit
// Debounce five keys by press lockout and auto-repeat left and right.
//
// Usage:
//   sample  - sink channel; each beat carries a millisecond stamp now_ms and
//             the five key levels (1 = active).
//   result  - source channel; exactly one beat per sample with five event
//             flags (accepted press, or auto-repeat on left/right) and the
//             five held flags after the update.
//   APB     - three 16-bit registers at byte addresses 0x0 (lockout),
//             0x4 (repeat start), 0x8 (repeat interval); write only while idle.
// Timing:
//   One sample per cycle unless intake stalls (see Stall). All five key lanes
//   evaluate in parallel and their state advances at the accepting edge; the
//   result beat appears on the next cycle. The rate is set by the lane update:
//   a 32-bit subtract and compare per timer, then one output register.
// Stall:
//   While a result beat waits, a new sample is still taken if the receiver
//   takes the waiting beat in the same cycle; otherwise sample.ready drops.
// Reset:
//   rst_n clears held flags, press and repeat stamps, and loads the register
//   defaults 50 / 500 / 100 ms. No clearing pass is needed.
// ============================================================================
`default_nettype none

module five_key_debounce_autorepeat_unit
    import fkda_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    fkda_in_if.sink                    sample,
    fkda_out_if.source                 result
);

    fkda_cfg_t             cfg_reg;
    fkda_reg_e             reg_sel;
    logic                  cfg_wr;
    logic                  accept;
    logic                  merge_ready;
    logic [NUM_KEYS-1:0]   levels;
    logic [TIME_WIDTH-1:0] now;
    fkda_result_t          res;

    // ------------------------------------------------------------------
    // Configuration port: pready is tied high, decode on the word index.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = fkda_reg_e'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_ms         <= LOCKOUT_RST;
            cfg_reg.repeat_start_ms    <= REPEAT_START_RST;
            cfg_reg.repeat_interval_ms <= REPEAT_INTERVAL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_LOCKOUT:         cfg_reg.lockout_ms         <= pwdata[CFG_WIDTH-1:0];
                REG_REPEAT_START:    cfg_reg.repeat_start_ms    <= pwdata[CFG_WIDTH-1:0];
                REG_REPEAT_INTERVAL: cfg_reg.repeat_interval_ms <= pwdata[CFG_WIDTH-1:0];
                default:             ; // drop writes past the last register
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LOCKOUT:         prdata = APB_DATA_W'(cfg_reg.lockout_ms);
            REG_REPEAT_START:    prdata = APB_DATA_W'(cfg_reg.repeat_start_ms);
            REG_REPEAT_INTERVAL: prdata = APB_DATA_W'(cfg_reg.repeat_interval_ms);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sample intake: a beat is taken whenever the output stage can move.
    // ------------------------------------------------------------------
    assign sample.ready = merge_ready;
    assign accept       = sample.valid && merge_ready;

    // Stamps wrap at TIME_WIDTH bits.
    assign now = TIME_WIDTH'(sample.now_ms);

    assign levels[KEY_UP]     = sample.level_up;
    assign levels[KEY_DOWN]   = sample.level_down;
    assign levels[KEY_LEFT]   = sample.level_left;
    assign levels[KEY_RIGHT]  = sample.level_right;
    assign levels[KEY_CENTER] = sample.level_center;

    // One lane per key; only left and right carry a repeat timer.
    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++)
        begin : g_lane
            fkda_lane #(
                .TIME_WIDTH (TIME_WIDTH),
                .HAS_REPEAT ((k == KEY_LEFT) || (k == KEY_RIGHT))
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .accept (accept),
                .level  (levels[k]),
                .now    (now),
                .cfg    (cfg_reg),
                .evt    (res.evt[k]),
                .held   (res.held[k])
            );
        end
    endgenerate

    // Output register: hold the beat until the receiver takes it.
    fkda_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (merge_ready),
        .res      (res),
        .result   (result)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // Any event (press or repeat) leaves its key held.
    a_event_implies_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((!result.event_up     || result.held_up)
                       && (!result.event_down   || result.held_down)
                       && (!result.event_left   || result.held_left)
                       && (!result.event_right  || result.held_right)
                       && (!result.event_center || result.held_center)))
        else $error("event reported on a key that is not held");

    // Every taken sample yields a result beat on the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted sample produced no result beat");

    // Intake stalls only behind a waiting, untaken result.
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready))
        else $error("sample intake stalled without backpressure");

    // Up, down and center never repeat; checked here for center: no event on two back-to-back samples while held.
    a_no_repeat_center: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.evt[KEY_CENTER]) ##1 (accept && sample.level_center)
            |-> !res.evt[KEY_CENTER])
        else $error("center key reported a repeat");

endmodule

`default_nettype wire

[rtl/fkda_lane.sv]
// ============================================================================
// fkda_lane
// One key: held flag, last press stamp, optional repeat stamp and timers.
// ============================================================================
`default_nettype none

module fkda_lane
    import fkda_pkg::*;
#(
    parameter int TIME_WIDTH = 32,
    parameter bit HAS_REPEAT = 1'b0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic                  level,
    input  wire logic [TIME_WIDTH-1:0] now,
    input  wire fkda_cfg_t             cfg,
    output logic                       evt,
    output logic                       held
);

    logic                  held_reg;
    logic                  held_next;
    logic [TIME_WIDTH-1:0] press_reg;
    logic [TIME_WIDTH-1:0] since_press;
    logic                  rise;
    logic                  press_ok;
    logic                  rep_due;

    assign rise        = level && !held_reg;
    assign since_press = now - press_reg;
    assign press_ok    = since_press > TIME_WIDTH'(cfg.lockout_ms);

    generate
        if (HAS_REPEAT)
        begin : g_rep
            logic [TIME_WIDTH-1:0] rep_reg;
            logic [TIME_WIDTH-1:0] since_rep;

            assign since_rep = now - rep_reg;
            assign rep_due   = held_reg && level
                            && (since_press > TIME_WIDTH'(cfg.repeat_start_ms))
                            && (since_rep > TIME_WIDTH'(cfg.repeat_interval_ms));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rep_reg <= '0;
                end
                else if (accept && !rise && rep_due)
                begin
                    rep_reg <= now;
                end
            end
        end
        else
        begin : g_norep
            assign rep_due = 1'b0;
        end
    endgenerate

    always_comb
    begin
        held_next = held_reg;
        evt       = 1'b0;
        if (rise)
        begin
            held_next = 1'b1;
            evt       = press_ok;
        end
        else if (rep_due)
        begin
            evt = 1'b1;
        end
        else if (held_reg && !level)
        begin
            held_next = 1'b0;
        end
    end

    assign held = held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            press_reg <= '0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            if (rise && press_ok)
            begin
                press_reg <= now;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/fkda_merge.sv]
// ============================================================================
// fkda_merge
// Collect the lane flags into one result beat and hold it for the receiver.
// ============================================================================
`default_nettype none

module fkda_merge
    import fkda_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fkda_result_t  res,
    fkda_out_if.source         result
);

    logic         valid_reg;
    fkda_result_t data_reg;

    assign in_ready = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.event_up     = data_reg.evt[KEY_UP];
    assign result.event_down   = data_reg.evt[KEY_DOWN];
    assign result.event_left   = data_reg.evt[KEY_LEFT];
    assign result.event_right  = data_reg.evt[KEY_RIGHT];
    assign result.event_center = data_reg.evt[KEY_CENTER];
    assign result.held_up      = data_reg.held[KEY_UP];
    assign result.held_down    = data_reg.held[KEY_DOWN];
    assign result.held_left    = data_reg.held[KEY_LEFT];
    assign result.held_right   = data_reg.held[KEY_RIGHT];
    assign result.held_center  = data_reg.held[KEY_CENTER];

endmodule

`default_nettype wire

[verif/keypad_event_checker.sv]
// ============================================================================
// keypad_event_checker
// Predicts key events and held flags from observed samples and checks results.
// Snoops APB writes for the timing registers and checks APB reads back.
// ============================================================================

module keypad_event_checker
    import fkda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    fkda_in_if                    sample,
    fkda_out_if                   result,
    output int                    mismatches,
    output int                    outstanding
);

    logic [NUM_KEYS-1:0]  held_keys;
    logic [31:0]          press_stamp [NUM_KEYS];
    logic [31:0]          repeat_stamp [2];
    logic [CFG_WIDTH-1:0] lockout_ms;
    logic [CFG_WIDTH-1:0] repeat_start_ms;
    logic [CFG_WIDTH-1:0] repeat_interval_ms;
    fkda_result_t         key_results_due [$];
    string                key_name [NUM_KEYS] = '{"up", "down", "left", "right", "center"};

    // Advance the key state by one sample and return the events and held flags.
    function automatic fkda_result_t predict_keys(input logic [31:0] now,
                                                  input logic [NUM_KEYS-1:0] level);
        fkda_result_t r;
        logic [31:0]  since_press;
        logic [31:0]  since_repeat;
        int           slot;
        r.evt = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            slot         = (k == KEY_RIGHT) ? 1 : 0;
            since_press  = now - press_stamp[k];
            since_repeat = now - repeat_stamp[slot];
            if (level[k] && !held_keys[k]) begin
                if (since_press > {16'b0, lockout_ms}) begin
                    press_stamp[k] = now;
                    r.evt[k]       = 1'b1;
                end
                held_keys[k] = 1'b1;
            end else if ((k == KEY_LEFT || k == KEY_RIGHT) && held_keys[k] && level[k] &&
                         since_press > {16'b0, repeat_start_ms} &&
                         since_repeat > {16'b0, repeat_interval_ms}) begin
                repeat_stamp[slot] = now;
                r.evt[k]           = 1'b1;
            end else if (held_keys[k] && !level[k]) begin
                held_keys[k] = 1'b0;
            end
        end
        r.held = held_keys;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n) begin
        fkda_result_t         got;
        fkda_result_t         want;
        logic [CFG_WIDTH-1:0] reg_value;
        if (!rst_n) begin
            held_keys          = '0;
            press_stamp        = '{default: '0};
            repeat_stamp       = '{default: '0};
            lockout_ms         = LOCKOUT_RST;
            repeat_start_ms    = REPEAT_START_RST;
            repeat_interval_ms = REPEAT_INTERVAL_RST;
            key_results_due.delete();
            mismatches         = 0;
            outstanding        = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_LOCKOUT:         lockout_ms         = pwdata[CFG_WIDTH-1:0];
                        REG_REPEAT_START:    repeat_start_ms    = pwdata[CFG_WIDTH-1:0];
                        REG_REPEAT_INTERVAL: repeat_interval_ms = pwdata[CFG_WIDTH-1:0];
                        default: ;
                    endcase
                end else begin
                    // unmapped slots read as zero
                    case (paddr[3:2])
                        REG_LOCKOUT:         reg_value = lockout_ms;
                        REG_REPEAT_START:    reg_value = repeat_start_ms;
                        REG_REPEAT_INTERVAL: reg_value = repeat_interval_ms;
                        default:             reg_value = '0;
                    endcase
                    if (prdata !== {16'b0, reg_value})
                        report_mismatch($sformatf("register read at 0x%0h", paddr),
                                        {16'b0, reg_value}, prdata);
                end
            end

            if (result.valid && result.ready) begin
                got.evt  = {result.event_center, result.event_right, result.event_left,
                            result.event_down, result.event_up};
                got.held = {result.held_center, result.held_right, result.held_left,
                            result.held_down, result.held_up};
                if (key_results_due.size() == 0) begin
                    report_mismatch("result beat count with no sample pending", 0, 1);
                end else begin
                    want = key_results_due.pop_front();
                    for (int k = 0; k < NUM_KEYS; k++) begin
                        if (got.evt[k] !== want.evt[k])
                            report_mismatch({"event_", key_name[k]}, want.evt[k], got.evt[k]);
                        if (got.held[k] !== want.held[k])
                            report_mismatch({"held_", key_name[k]}, want.held[k], got.held[k]);
                    end
                end
            end

            if (sample.valid && sample.ready)
                key_results_due.push_back(predict_keys(sample.now_ms,
                    {sample.level_center, sample.level_right, sample.level_left,
                     sample.level_down, sample.level_up}));

            outstanding = key_results_due.size();
        end
    end

endmodule

[verif/tb_five_key_debounce_autorepeat_unit.sv]
// ============================================================================
// tb_five_key_debounce_autorepeat_unit
// Stimulus and verdict for the five-key debounce and auto-repeat unit.
// Drives timestamped key samples and APB register writes; a checker module
// beside the DUT predicts every result beat and counts mismatches.
// ============================================================================

module tb_five_key_debounce_autorepeat_unit;
    import fkda_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PRESSURE_AT   = 420;   // samples sent before the long stall
    localparam int          HOLD_CYCLES   = 64;    // length of the long result stall
    localparam int          RANDOM_PHASES = 5;
    localparam int          PHASE_ITEMS   = 130;
    // Unmapped register slot; writes there must be dropped.
    localparam logic [1:0]  REG_SPARE     = 2'd3;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    outstanding;
    int                    samples_sent = 0;
    int                    settings_used = 0;
    int                    cycles = 0;
    bit                    calm = 1'b0;        // no idling on either side while set
    bit                    stall_done = 1'b0;

    fkda_in_if  sample_ch ();
    fkda_out_if result_ch ();

    five_key_debounce_autorepeat_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    keypad_event_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .sample      (sample_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 8-unit clock: high for 4, low for 4
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: end the run as failed if the cycle limit is reached.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Result receiver. Every negedge assigns ready exactly once: a single long
    // hold-off once enough samples went in (the sender keeps offering, so the
    // output register fills and sample.ready must drop), random stalls otherwise (none while calm).
    initial
    begin
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!stall_done && samples_sent >= PRESSURE_AT)
            begin
                stall_done = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= calm || ($urandom_range(99) >= 20);
            end
        end
    end

    // All tasks below are entered at a negedge where nothing has been driven yet,
    // and return at a later negedge in the same condition.

    // Offer one sample, optionally after a random gap, and hold it until accepted.
    task automatic push_sample(input logic [31:0] stamp, input logic [NUM_KEYS-1:0] lv);
        int gap;
        gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.now_ms       <= stamp;
        sample_ch.level_up     <= lv[KEY_UP];
        sample_ch.level_down   <= lv[KEY_DOWN];
        sample_ch.level_left   <= lv[KEY_LEFT];
        sample_ch.level_right  <= lv[KEY_RIGHT];
        sample_ch.level_center <= lv[KEY_CENTER];
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every result beat has been taken.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // One APB transfer: setup cycle, access cycle, then a cycle with psel low.
    task automatic apb_access(input logic write, input logic [1:0] idx,
                              input logic [CFG_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        // upper bits carry junk; the registers are only 16 bits wide
        pwdata  <= {16'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Write all three timing registers and read them back.
    task automatic load_settings(input logic [CFG_WIDTH-1:0] lockout,
                                 input logic [CFG_WIDTH-1:0] start,
                                 input logic [CFG_WIDTH-1:0] interval);
        apb_access(1'b1, REG_LOCKOUT, lockout);
        apb_access(1'b1, REG_REPEAT_START, start);
        apb_access(1'b1, REG_REPEAT_INTERVAL, interval);
        apb_access(1'b0, REG_LOCKOUT, '0);
        apb_access(1'b0, REG_REPEAT_START, '0);
        apb_access(1'b0, REG_REPEAT_INTERVAL, '0);
        settings_used++;
    endtask

    // Random samples shaped like real key activity: time mostly moves forward by
    // up to step_max ms, keys toggle now and then (left/right are held longer so
    // they reach auto-repeat), with occasional time jumps and level noise.
    task automatic run_random(input int count, input int step_max,
                              inout logic [31:0] clock_ms, inout logic [NUM_KEYS-1:0] keys);
        logic [NUM_KEYS-1:0] flip;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 8)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);
            for (int k = 0; k < NUM_KEYS; k++)
                flip[k] = $urandom_range(99) < ((k == KEY_LEFT || k == KEY_RIGHT) ? 12 : 30);
            keys = keys ^ flip;
            if ($urandom_range(99) < 5)
                keys = NUM_KEYS'($urandom());
            push_sample(clock_ms, keys);
        end
    endtask

    initial
    begin
        logic [31:0]          clock_ms;
        logic [NUM_KEYS-1:0]  keys;
        logic [CFG_WIDTH-1:0] lo;
        logic [CFG_WIDTH-1:0] st;
        logic [CFG_WIDTH-1:0] iv;
        int                   step_max;

        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.now_ms       = '0;
        sample_ch.level_up     = 1'b0;
        sample_ch.level_down   = 1'b0;
        sample_ch.level_left   = 1'b0;
        sample_ch.level_right  = 1'b0;
        sample_ch.level_center = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, reset timing 50 / 500 / 100 ms ----
        push_sample(32'd0, 5'b00000);
        // rising edge too soon after the reset stamp: held, but no press
        push_sample(32'd10, 5'b11111);
        push_sample(32'd20, 5'b00000);
        // accepted press on every key
        push_sample(32'd100, 5'b11111);
        // left/right repeat after the start delay
        push_sample(32'd700, 5'b11111);
        // still active, repeat interval not yet elapsed: stay held, no event
        push_sample(32'd750, 5'b11111);
        push_sample(32'd801, 5'b11111);
        push_sample(32'd802, 5'b00000);
        push_sample(32'd840, 5'b11111);
        push_sample(32'd841, 5'b00000);
        // rejected press keeps the older stamp; the repeat is timed from 840
        push_sample(32'd860, 5'b11111);
        push_sample(32'd1341, 5'b11111);
        // timestamp wrap-around
        push_sample(32'hFFFF_FFF0, 5'b00000);
        push_sample(32'hFFFF_FFFF, 5'b11111);
        push_sample(32'h0000_0300, 5'b11111);
        push_sample(32'hAAAA_AAAA, 5'b10101);
        push_sample(32'h5555_5555, 5'b01010);
        settle();

        // all timers at zero: every new millisecond repeats, equal stamps do not
        load_settings('0, '0, '0);
        push_sample(32'd5000, 5'b11111);
        push_sample(32'd5000, 5'b11111);
        push_sample(32'd5001, 5'b11111);
        settle();

        // a write to the unmapped slot must leave the registers alone
        apb_access(1'b1, REG_SPARE, 16'hFFFF);
        apb_access(1'b0, REG_LOCKOUT, '0);
        apb_access(1'b0, REG_REPEAT_START, '0);
        apb_access(1'b0, REG_REPEAT_INTERVAL, '0);
        apb_access(1'b0, REG_SPARE, '0);
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_sample(32'd5002, 5'b00000);
        push_sample(32'd5003, 5'b11111);
        push_sample(32'd70539, 5'b11111);
        settle();

        // ---- random part, one register setting per phase ----
        clock_ms = 32'd100000;
        keys     = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: begin lo = LOCKOUT_RST; st = REPEAT_START_RST; iv = REPEAT_INTERVAL_RST; end
                1: begin lo = '0; st = '0; iv = '0; end
                2: begin lo = 16'hFFFF; st = 16'hFFFF; iv = 16'hFFFF; end
                3:
                begin
                    lo = CFG_WIDTH'($urandom_range(0, 1000));
                    st = CFG_WIDTH'($urandom_range(0, 1000));
                    iv = CFG_WIDTH'($urandom_range(0, 1000));
                end
                default:
                begin
                    lo = CFG_WIDTH'($urandom());
                    st = CFG_WIDTH'($urandom());
                    iv = CFG_WIDTH'($urandom());
                end
            endcase
            // scale the time steps to the setting so presses are both
            // accepted and rejected
            step_max = ((lo > st) ? lo : st) / 2 + 3;
            load_settings(lo, st, iv);
            calm = (ph == 1);
            run_random(PHASE_ITEMS, step_max, clock_ms, keys);
            calm = 1'b0;
            settle();
        end

        // drain before the final report
        repeat (4) @(negedge clk);
        $display("Covered %0d samples over %0d register settings with a %0d-cycle result stall.",
                 samples_sent, settings_used, HOLD_CYCLES);
        $display("Included wrapped stamps, rejected presses, zero and full-scale timers.");
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
